[sv/gchg_pkg.sv]
// ----------------------------------------------------------------------------
// gchg_pkg: shared types and constants of the greedy change dispenser
// beat layouts, note tables, status codes and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package gchg_pkg;

  localparam int NOTE_KINDS      = 5;
  localparam int NOTE_IDX_W      = 3;
  localparam int PRICE_W         = 16;
  localparam int PAID_W          = 8;
  localparam int GIVE_W          = 15;
  localparam int STATUS_W        = 2;
  localparam int NOTE_VAL_W      = 6;
  localparam int COUNT_WIDTH_DEF = 16;

  // reciprocal divide: q = (x * ceil(2^21 / d)) >> 21 is exact for x < 2^15, d <= 50
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FAILED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 2'd2;

  localparam logic [NOTE_IDX_W-1:0] NOTE_ONE     = 3'd0;
  localparam logic [NOTE_IDX_W-1:0] NOTE_FIVE    = 3'd1;
  localparam logic [NOTE_IDX_W-1:0] NOTE_TEN     = 3'd2;
  localparam logic [NOTE_IDX_W-1:0] NOTE_TWENTY  = 3'd3;
  localparam logic [NOTE_IDX_W-1:0] NOTE_FIFTY   = 3'd4;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [PAID_W-1:0]  paid_ones;
    logic [PAID_W-1:0]  paid_fives;
    logic [PAID_W-1:0]  paid_tens;
    logic [PAID_W-1:0]  paid_twenties;
    logic [PAID_W-1:0]  paid_fifties;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GIVE_W-1:0]   give_ones;
    logic [GIVE_W-1:0]   give_fives;
    logic [GIVE_W-1:0]   give_tens;
    logic [GIVE_W-1:0]   give_twenties;
    logic [GIVE_W-1:0]   give_fifties;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIFF,
    ST_DIV,
    ST_TAKE,
    ST_COMMIT,
    ST_RESULT
  } gchg_state_t;

  function automatic logic [NOTE_VAL_W-1:0] note_value(input logic [NOTE_IDX_W-1:0] idx);
    logic [NOTE_VAL_W-1:0] v;
    unique case (idx)
      NOTE_ONE:    v = 6'd1;
      NOTE_FIVE:   v = 6'd5;
      NOTE_TEN:    v = 6'd10;
      NOTE_TWENTY: v = 6'd20;
      NOTE_FIFTY:  v = 6'd50;
      default:     v = 6'd0;
    endcase
    return v;
  endfunction

  function automatic logic [RECIP_W-1:0] note_recip(input logic [NOTE_IDX_W-1:0] idx);
    logic [RECIP_W-1:0] r;
    unique case (idx)
      NOTE_ONE:    r = 22'd2097152;
      NOTE_FIVE:   r = 22'd419431;
      NOTE_TEN:    r = 22'd209716;
      NOTE_TWENTY: r = 22'd104858;
      NOTE_FIFTY:  r = 22'd41944;
      default:     r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/greedy_change_dispenser.sv]
// ----------------------------------------------------------------------------
// greedy_change_dispenser: note inventory with greedy change making
// one purchase per command, change drawn largest note first from the stock
// ----------------------------------------------------------------------------
//
//  channel  ports                   handshake
//  -------  ----------------------  ------------------------------------------
//  input    start, busy, in_item    beat taken on a clock edge with start & !busy
//  result   out_valid, out_item     one-cycle strobe, receiver cannot stall
//
//  a purchase steps from accept to its result strobe: sum the paid notes,
//  form the change, then a divide and a take on the shared reciprocal
//  divider and take unit for each note value (five values), commit the
//  stock, and the result; busy stays high through the result cycle
//  failure paths are shorter: underpaid skips divide, take and commit, ignored
//  skips to the result; reset (synchronous, active low) empties the stock and
//  clears the failure flag; the block comes out of reset idle, with busy low
//
`default_nettype none

module greedy_change_dispenser
  import gchg_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output      logic      busy,
  input  wire in_item_t  in_item,
  output      logic      out_valid,
  output      out_item_t out_item
);

  localparam int CMP_W   = (COUNT_WIDTH > GIVE_W) ? COUNT_WIDTH : GIVE_W;
  localparam int PROD_W  = GIVE_W + RECIP_W;
  localparam int TPROD_W = GIVE_W + NOTE_VAL_W;
  localparam int UPD_W   = COUNT_WIDTH + 1;

  // sequencer
  gchg_state_t state_r, state_nxt;

  // captured purchase and working registers
  in_item_t               in_r;
  logic [PRICE_W-1:0]     paid_total_r;
  logic [GIVE_W-1:0]      change_r;
  logic [GIVE_W-1:0]      quot_r;
  logic [NOTE_IDX_W-1:0]  k_r;
  logic [GIVE_W-1:0]      give_r [NOTE_KINDS];
  logic [STATUS_W-1:0]    status_r;

  // persistent state
  logic [COUNT_WIDTH-1:0] inv_r [NOTE_KINDS];
  logic                   failed_r;

  // paid counts as an array, order 1, 5, 10, 20, 50
  logic [PAID_W-1:0] paid [NOTE_KINDS];
  assign paid[0] = in_r.paid_ones;
  assign paid[1] = in_r.paid_fives;
  assign paid[2] = in_r.paid_tens;
  assign paid[3] = in_r.paid_twenties;
  assign paid[4] = in_r.paid_fifties;

  // weighted sum of the paid notes, at most 21930
  logic [PRICE_W-1:0] paid_sum;
  always_comb begin
    paid_sum = '0;
    for (int i = 0; i < NOTE_KINDS; i++) begin
      paid_sum = paid_sum + PRICE_W'(paid[i]) * PRICE_W'(note_value(NOTE_IDX_W'(i)));
    end
  end

  // shared divider: change / note value by reciprocal multiply
  logic [PROD_W-1:0] div_prod;
  assign div_prod = PROD_W'(change_r) * PROD_W'(note_recip(k_r));

  // take unit: bounded by the stock, then pulled from the remaining change
  logic [GIVE_W-1:0]  take;
  logic [TPROD_W-1:0] take_amt;
  always_comb begin
    if (CMP_W'(quot_r) <= CMP_W'(inv_r[k_r])) begin
      take = quot_r;
    end else begin
      take = GIVE_W'(inv_r[k_r]);
    end
    take_amt = TPROD_W'(take) * TPROD_W'(note_value(k_r));
  end

  // stock update per note lane, saturating at the counter max
  logic [COUNT_WIDTH-1:0] inv_upd [NOTE_KINDS];
  always_comb begin
    for (int i = 0; i < NOTE_KINDS; i++) begin
      logic [UPD_W-1:0] s;
      s = UPD_W'(inv_r[i]) - UPD_W'(give_r[i]) + UPD_W'(paid[i]);
      if (s[COUNT_WIDTH]) begin
        inv_upd[i] = '1;
      end else begin
        inv_upd[i] = s[COUNT_WIDTH-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = failed_r ? ST_RESULT : ST_SUM;
        end
      end
      ST_SUM:    state_nxt = ST_DIFF;
      ST_DIFF: begin
        state_nxt = (paid_total_r < in_r.price) ? ST_RESULT : ST_DIV;
      end
      ST_DIV:    state_nxt = ST_TAKE;
      ST_TAKE: begin
        state_nxt = (k_r == NOTE_ONE) ? ST_COMMIT : ST_DIV;
      end
      ST_COMMIT: state_nxt = ST_RESULT;
      ST_RESULT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy                   = (state_r != ST_IDLE);
    out_valid              = (state_r == ST_RESULT);
    out_item.status        = status_r;
    out_item.give_ones     = give_r[0];
    out_item.give_fives    = give_r[1];
    out_item.give_tens     = give_r[2];
    out_item.give_twenties = give_r[3];
    out_item.give_fifties  = give_r[4];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      failed_r <= 1'b0;
      for (int i = 0; i < NOTE_KINDS; i++) begin
        inv_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_DIFF: begin
          if (paid_total_r < in_r.price) begin
            failed_r <= 1'b1;
          end
        end
        ST_COMMIT: begin
          // leftover change means the stock could not make it exactly
          if (change_r != '0) begin
            failed_r <= 1'b1;
          end else begin
            for (int i = 0; i < NOTE_KINDS; i++) begin
              inv_r[i] <= inv_upd[i];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          in_r     <= in_item;
          status_r <= STATUS_IGNORED;
          for (int i = 0; i < NOTE_KINDS; i++) begin
            give_r[i] <= '0;
          end
        end
      end
      ST_SUM: begin
        paid_total_r <= paid_sum;
      end
      ST_DIFF: begin
        // paid total fits 15 bits, so does the change
        change_r <= GIVE_W'(paid_total_r - in_r.price);
        status_r <= STATUS_FAILED;
        k_r      <= NOTE_FIFTY;
      end
      ST_DIV: begin
        quot_r <= div_prod[RECIP_SHIFT +: GIVE_W];
      end
      ST_TAKE: begin
        give_r[k_r] <= take;
        change_r    <= change_r - GIVE_W'(take_amt);
        k_r         <= k_r - NOTE_IDX_W'(1);
      end
      ST_COMMIT: begin
        if (change_r != '0) begin
          status_r <= STATUS_FAILED;
          for (int i = 0; i < NOTE_KINDS; i++) begin
            give_r[i] <= '0;
          end
        end else begin
          status_r <= STATUS_ACCEPTED;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: greedy change dispenser
// sends purchases over the start/busy handshake, predicts status and notes
// given back from a private copy of the note stock, and checks every strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import gchg_pkg::*;

  localparam int              STOCK_W      = COUNT_WIDTH_DEF;
  localparam longint unsigned STOCK_MAX    = (64'd1 << STOCK_W) - 64'd1;
  localparam int              QUIET_LIMIT  = 1000;
  localparam int              DRAIN_CYCLES = 40;
  localparam int              MAX_GAP      = 20;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // predicted state of the dispenser
  longint unsigned note_stock [NOTE_KINDS];
  longint unsigned draw_plan  [NOTE_KINDS];
  bit              locked_out;

  out_item_t pending_change [$];
  out_item_t due_change;
  int        error_count  = 0;
  int        quiet_cycles = 0;
  int        idle_pct;
  // lean runs hand in no ones in random and saturation purchases, so the stock of ones can run dry
  bit        lean_run;

  greedy_change_dispenser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic longint unsigned note_worth(input int k);
    case (k)
      NOTE_ONE:    return 1;
      NOTE_FIVE:   return 5;
      NOTE_TEN:    return 10;
      NOTE_TWENTY: return 20;
      default:     return 50;
    endcase
  endfunction

  function automatic longint unsigned paid_count(input in_item_t p, input int k);
    case (k)
      NOTE_ONE:    return p.paid_ones;
      NOTE_FIVE:   return p.paid_fives;
      NOTE_TEN:    return p.paid_tens;
      NOTE_TWENTY: return p.paid_twenties;
      default:     return p.paid_fifties;
    endcase
  endfunction

  // amount handed in with one purchase
  function automatic longint unsigned tendered(input in_item_t p);
    longint unsigned sum;
    int k;
    sum = 0;
    for (k = 0; k < NOTE_KINDS; k++) sum += paid_count(p, k) * note_worth(k);
    return sum;
  endfunction

  function automatic longint unsigned stock_worth();
    longint unsigned sum;
    int k;
    sum = 0;
    for (k = 0; k < NOTE_KINDS; k++) sum += note_stock[k] * note_worth(k);
    return sum;
  endfunction

  // greedy draw, largest note first, limited by what the stock holds;
  // fills draw_plan and returns the part of the amount left uncovered
  function automatic longint unsigned plan_change(input longint unsigned amount);
    longint unsigned want;
    int k;
    for (k = NOTE_KINDS - 1; k >= 0; k--) begin
      want         = amount / note_worth(k);
      draw_plan[k] = (want < note_stock[k]) ? want : note_stock[k];
      amount      -= draw_plan[k] * note_worth(k);
    end
    return amount;
  endfunction

  // expected result of one accepted purchase; updates the predicted stock
  function automatic out_item_t dispense(input in_item_t p);
    out_item_t       res;
    longint unsigned paid;
    longint unsigned level;
    int k;
    res        = '0;
    res.status = STATUS_ACCEPTED;
    paid       = tendered(p);
    if (locked_out) begin
      res.status = STATUS_IGNORED;
    end else if (paid < p.price) begin
      // underpaid: stock untouched
      locked_out = 1'b1;
      res.status = STATUS_FAILED;
    end else if (plan_change(paid - p.price) != 0) begin
      // change cannot be made exactly: nothing leaves, nothing is added
      locked_out = 1'b1;
      res.status = STATUS_FAILED;
    end else begin
      // change leaves first, then the paid notes go in, counts saturate
      for (k = 0; k < NOTE_KINDS; k++) begin
        level         = note_stock[k] - draw_plan[k] + paid_count(p, k);
        note_stock[k] = (level > STOCK_MAX) ? STOCK_MAX : level;
      end
      res.give_ones     = GIVE_W'(draw_plan[NOTE_ONE]);
      res.give_fives    = GIVE_W'(draw_plan[NOTE_FIVE]);
      res.give_tens     = GIVE_W'(draw_plan[NOTE_TEN]);
      res.give_twenties = GIVE_W'(draw_plan[NOTE_TWENTY]);
      res.give_fifties  = GIVE_W'(draw_plan[NOTE_FIFTY]);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_purchase(input int price, input int ones,
      input int fives, input int tens, input int twenties, input int fifties);
    in_item_t p;
    p.price         = PRICE_W'(price);
    p.paid_ones     = PAID_W'(ones);
    p.paid_fives    = PAID_W'(fives);
    p.paid_tens     = PAID_W'(tens);
    p.paid_twenties = PAID_W'(twenties);
    p.paid_fifties  = PAID_W'(fifties);
    return p;
  endfunction

  // price equal to what is handed in, so no change is due
  function automatic in_item_t exact_purchase(input int ones, input int fives,
      input int tens, input int twenties, input int fifties);
    in_item_t p;
    p       = make_purchase(0, ones, fives, tens, twenties, fifties);
    p.price = PRICE_W'(tendered(p));
    return p;
  endfunction

  // any field value at all, used for noise and for purchases after lockout
  function automatic in_item_t any_item();
    return make_purchase($urandom_range(65535), $urandom_range(255),
                         $urandom_range(255), $urandom_range(255),
                         $urandom_range(255), $urandom_range(255));
  endfunction

  // note counts leaning toward zero, full and small values
  function automatic logic [PAID_W-1:0] random_count(input bit allowed);
    if (!allowed) return '0;
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PAID_W'($urandom_range(255));
      default: return PAID_W'($urandom_range(12));
    endcase
  endfunction

  // set the price so that the change due can be made from the current stock
  function automatic in_item_t price_for_change(input in_item_t p);
    longint unsigned paid;
    longint unsigned cap;
    longint unsigned change;
    paid = tendered(p);
    cap  = stock_worth();
    if (cap > paid) cap = paid;
    case ($urandom_range(3))
      0:       change = 0;
      1:       change = $urandom_range(32'((cap < 60) ? cap : 60));
      default: change = $urandom_range(32'(cap));
    endcase
    // trim what greedy cannot cover, give up on change if still short
    change -= plan_change(change);
    if (plan_change(change) != 0) change = 0;
    p.price = PRICE_W'(paid - change);
    return p;
  endfunction

  function automatic in_item_t random_purchase();
    in_item_t p;
    p.price         = '0;
    p.paid_ones     = random_count(!lean_run);
    p.paid_fives    = random_count(1'b1);
    p.paid_tens     = random_count(1'b1);
    p.paid_twenties = random_count(1'b1);
    p.paid_fifties  = random_count(1'b1);
    return price_for_change(p);
  endfunction

  // one beat on the command port; start is dropped only for an idle gap,
  // with junk on in_item meanwhile, and the expectation is formed on accept
  task automatic send_purchase(input in_item_t p);
    if ($urandom_range(99) < idle_pct) begin
      start   = 1'b0;
      in_item = any_item();
      repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
    end
    start   = 1'b1;
    in_item = p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_change.push_back(dispense(p));
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // short hand-picked purchases starting from an empty stock
  task automatic test_directed_purchases();
    // nothing owed, nothing paid
    send_purchase(make_purchase(0, 0, 0, 0, 0, 0));
    // exact payment seeds one note of each value
    send_purchase(exact_purchase(1, 1, 1, 1, 1));
    // change of 85 takes one fifty, twenty, ten and five
    send_purchase(make_purchase(15, 0, 0, 0, 0, 2));
    // change of 100 takes both fifties
    send_purchase(make_purchase(0, 100, 0, 0, 0, 0));
    // no larger notes left: change of 49 falls through to ones
    send_purchase(make_purchase(1, 0, 0, 0, 0, 1));
    // largest amount that can be paid, exactly
    send_purchase(exact_purchase(255, 255, 255, 255, 255));
    // 255 fifties back as change
    send_purchase(make_purchase(0, 0, 0, 0, 0, 255));
    // alternating bit patterns in every count
    send_purchase(exact_purchase(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
    send_purchase(exact_purchase(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
    // change that uses every note value
    send_purchase(make_purchase(14, 0, 0, 0, 0, 2));
    send_purchase(make_purchase(1, 0, 0, 0, 0, 255));
  endtask

  task automatic test_random_purchases(input int count);
    int n;
    for (n = 0; n < count; n++) send_purchase(random_purchase());
  endtask

  // back-to-back full payments drive the counts into saturation
  task automatic test_stock_saturation();
    int n;
    idle_pct = 0;
    for (n = 0; n < 260; n++)
      send_purchase(exact_purchase(lean_run ? 0 : 255, 255, 255, 255, 255));
    idle_pct = 37;
  endtask

  // trip the sticky failure, then everything after it must be ignored
  task automatic test_failure_lockout();
    in_item_t p;
    int n;
    if ($urandom_range(1) == 1 && note_stock[NOTE_ONE] < 4) begin
      // one unit more change than there are ones
      p = make_purchase(4 - int'(note_stock[NOTE_ONE]), 0, 1, 0, 0, 0);
    end else begin
      p       = any_item();
      p.price = PRICE_W'($urandom_range(65535, 32'(tendered(p) + 1)));
    end
    send_purchase(p);
    for (n = 0; n < 40; n++) send_purchase(any_item());
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string field, input logic [15:0] want,
      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  // each strobe is taken at the edge that closes its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_change.size() == 0) begin
        $error("result beat with no purchase outstanding, status %0d", out_item.status);
        error_count++;
      end else begin
        due_change = pending_change.pop_front();
        check_field("status", 16'(due_change.status), 16'(out_item.status));
        check_field("give_ones", 16'(due_change.give_ones), 16'(out_item.give_ones));
        check_field("give_fives", 16'(due_change.give_fives), 16'(out_item.give_fives));
        check_field("give_tens", 16'(due_change.give_tens), 16'(out_item.give_tens));
        check_field("give_twenties", 16'(due_change.give_twenties),
                    16'(out_item.give_twenties));
        check_field("give_fifties", 16'(due_change.give_fifties),
                    16'(out_item.give_fifties));
      end
    end
  end

  // watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    int k;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    for (k = 0; k < NOTE_KINDS; k++) note_stock[k] = 0;
    locked_out = 1'b0;
    idle_pct   = 37;
    lean_run   = ($urandom_range(1) == 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_purchases();
    test_random_purchases(420);
    test_stock_saturation();
    test_random_purchases(350);
    test_failure_lockout();
    start = 1'b0;

    // let outstanding results arrive, then watch for strays
    while (pending_change.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
